FILE: sv/pst_pkg.sv
// Session table package: table depth, slot index width, outcome codes and
// the entry and result types. No dependencies.
package pst_pkg;

	localparam int SESSIONS = 8;
	localparam int SLOT_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

	localparam logic [15:0] BASE_RESET = 16'd40000;

	localparam logic [1:0] OUTCOME_HIT  = 2'd0;
	localparam logic [1:0] OUTCOME_NEW  = 2'd1;
	localparam logic [1:0] OUTCOME_FULL = 2'd2;

	typedef struct packed {
		logic [31:0] address;
		logic [15:0] lan_port;
		logic [15:0] wan_port;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]        outcome;
		logic [15:0]       wan_port;
		logic [SLOT_W-1:0] slot;
	} result_t;

endpackage

FILE: sv/pst_ram.sv
// Generic single-clock RAM, one write port and one read port,
// read data registered. No dependencies.
module pst_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = 3
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: sv/pst_lookup.sv
// Session lookup: scans the entry RAM one slot a cycle, then resolves hit,
// new session or table full. Depends on pst_pkg and pst_ram.
module pst_lookup (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            key_address,
	input  logic [15:0]            key_port,
	input  logic                   base_load,
	input  logic [15:0]            base_value,
	input  logic                   res_ready,
	output logic                   busy,
	output logic                   res_valid,
	output pst_pkg::result_t       res
);

	import pst_pkg::*;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SCAN    = 2'd1;
	localparam logic [1:0] ST_DRAIN   = 2'd2;
	localparam logic [1:0] ST_RESOLVE = 2'd3;

	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SESSIONS - 1);

	logic [1:0]          state_q;
	logic [SLOT_W-1:0]   scan_idx_q;
	logic [31:0]         key_addr_q;
	logic [15:0]         key_port_q;
	logic [SESSIONS-1:0] slot_valid_q;
	logic [15:0]         next_port_q;

	logic                rd_valid_s1;
	logic                rd_last_s1;
	logic [SLOT_W-1:0]   rd_idx_s1;
	logic [ENTRY_W-1:0]  rd_data;
	entry_t              rd_entry;

	logic                hit_q;
	logic [SLOT_W-1:0]   hit_idx_q;
	logic [15:0]         hit_port_q;
	logic                free_q;
	logic [SLOT_W-1:0]   free_idx_q;

	logic                match;
	logic                fire;
	logic                wr_new;
	entry_t              wr_entry;

	assign rd_entry = entry_t'(rd_data);
	assign match = rd_valid_s1 && slot_valid_q[rd_idx_s1] &&
		rd_entry.address == key_addr_q && rd_entry.lan_port == key_port_q;

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_RESOLVE) && res_ready;
	assign fire      = res_valid;
	assign wr_new    = fire && !hit_q && free_q;

	assign wr_entry.address  = key_addr_q;
	assign wr_entry.lan_port = key_port_q;
	assign wr_entry.wan_port = next_port_q;

	always_comb begin
		if (hit_q) begin
			res.outcome  = OUTCOME_HIT;
			res.wan_port = hit_port_q;
			res.slot     = hit_idx_q;
		end else if (free_q) begin
			res.outcome  = OUTCOME_NEW;
			res.wan_port = next_port_q;
			res.slot     = free_idx_q;
		end else begin
			res.outcome  = OUTCOME_FULL;
			res.wan_port = '0;
			res.slot     = '0;
		end
	end

	pst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SESSIONS),
		.ADDR_W(SLOT_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_new),
		.wr_addr(free_idx_q),
		.wr_data(ENTRY_W'(wr_entry)),
		.rd_addr(scan_idx_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk) begin
		if (start) begin
			key_addr_q <= key_address;
			key_port_q <= key_port;
		end
		rd_idx_s1  <= scan_idx_q;
		rd_last_s1 <= (scan_idx_q == LAST);
		if (match && !hit_q) begin
			hit_idx_q  <= rd_idx_s1;
			hit_port_q <= rd_entry.wan_port;
		end
		if (rd_valid_s1 && !slot_valid_q[rd_idx_s1] && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_idx_q   <= '0;
			rd_valid_s1  <= 1'b0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			slot_valid_q <= '0;
			next_port_q  <= BASE_RESET;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (match) begin
				hit_q <= 1'b1;
			end
			if (rd_valid_s1 && !slot_valid_q[rd_idx_s1]) begin
				free_q <= 1'b1;
			end
			if (base_load) begin
				next_port_q <= base_value;
			end else if (wr_new) begin
				next_port_q <= (next_port_q == 16'hFFFF) ? base_value : next_port_q + 16'd1;
			end
			if (wr_new) begin
				slot_valid_q[free_idx_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					scan_idx_q <= '0;
					if (start) begin
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == LAST) begin
						scan_idx_q <= '0;
						state_q    <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (rd_valid_s1 && rd_last_s1) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_full_means_all_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.outcome == OUTCOME_FULL |-> &slot_valid_q)
		else $error("table full reported with a free slot");

	a_new_adds_one: assert property (@(posedge clk) disable iff (!arst_n)
		wr_new |=> $countones(slot_valid_q) == $past($countones(slot_valid_q)) + 1)
		else $error("new session did not occupy exactly one free slot");

	a_hit_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.outcome == OUTCOME_HIT |-> slot_valid_q[hit_idx_q])
		else $error("hit on an empty slot");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == ST_SCAN))
		else $error("compare stage active outside a scan");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN || state_q == ST_DRAIN |-> !wr_new)
		else $error("table written while scan in progress");
`endif

endmodule

FILE: sv/pat_session_table_top.sv
// Port address translation session table, top level: ports, base register
// and result register. Depends on pst_pkg and pst_lookup.
//
// Each packet keeps the lookup busy from accept until its result is taken: the
// single read port of the entry RAM is scanned one slot per cycle, then a drain
// state takes the last read and a resolve state holds the outcome until the
// output register can take it. The result then moves to the output register,
// and the next packet is accepted once the lookup is back in idle, even if
// that result is still stalled; a later result waits in the lookup while the
// output register holds a stalled beat.
// Public ports count up from base_public_port and wrap back to it after
// 65535; a write to base_public_port also restarts the count at the new base.
module pat_session_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] base_public_port,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] private_address,
	input  logic [15:0] private_port_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  outcome,
	output logic [15:0] public_port_out,
	output logic [2:0]  slot_index
);

	import pst_pkg::*;

	logic        base_q;
	logic [15:0] base_port_q;
	logic        cfg_fire;
	logic        start;
	logic        busy;
	logic        res_ready;
	logic        res_valid;
	result_t     res;
	logic        out_valid_q;
	logic [1:0]  outcome_q;
	logic [15:0] public_port_q;
	logic [2:0]  slot_index_q;

	assign cfg_ready = base_q;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_stall  = busy;
	assign start     = in_valid && !busy;
	assign res_ready = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign outcome         = outcome_q;
	assign public_port_out = public_port_q;
	assign slot_index      = slot_index_q;

	pst_lookup u_lookup (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.key_address(private_address),
		.key_port   (private_port_in),
		.base_load  (cfg_fire),
		.base_value (cfg_fire ? base_public_port : base_port_q),
		.res_ready  (res_ready),
		.busy       (busy),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk) begin
		if (res_valid) begin
			outcome_q     <= res.outcome;
			public_port_q <= res.wan_port;
			slot_index_q  <= 3'(res.slot);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= 1'b0;
			base_port_q <= BASE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			base_q <= 1'b1;
			if (cfg_fire) begin
				base_port_q <= base_public_port;
			end
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
